// ===== design/compacting_array_delete_defines.svh =====
`ifndef COMPACTING_ARRAY_DELETE_DEFINES_SVH
`define COMPACTING_ARRAY_DELETE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CAD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("compacting array check failed");

// next-cycle implication, checked while out of reset
`define CAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("compacting array check failed");

`endif

// ===== design/cad_pkg.sv =====
package cad_pkg;

  localparam int ActW    = 3;
  localparam int PosW    = 4;
  localparam int DataW   = 32;
  localparam int CntOutW = 5;
  localparam int StatW   = 2;
  localparam int StepW   = 4;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_DEL_AT    = 3'd1,
    ACT_DEL_FIRST = 3'd2,
    ACT_DEL_LAST  = 3'd3,
    ACT_DEL_VALUE = 3'd4,
    ACT_READ      = 3'd5
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef logic [StepW-1:0] step_t;

  localparam step_t UpcFetch    = 4'd0;
  localparam step_t UpcDecode   = 4'd1;
  localparam step_t UpcAppend   = 4'd2;
  localparam step_t UpcRdIssue  = 4'd3;
  localparam step_t UpcRdTake   = 4'd4;
  localparam step_t UpcDropLast = 4'd5;
  localparam step_t UpcLoopRd   = 4'd6;
  localparam step_t UpcLoopStep = 4'd7;
  localparam step_t UpcLoopEnd  = 4'd8;
  localparam step_t UpcDone     = 4'd9;

  typedef enum logic [3:0] {
    CMD_NOP       = 4'd0,
    CMD_FETCH     = 4'd1,
    CMD_DECODE    = 4'd2,
    CMD_APPEND    = 4'd3,
    CMD_RD_ISSUE  = 4'd4,
    CMD_RD_TAKE   = 4'd5,
    CMD_DROP_LAST = 4'd6,
    CMD_LOOP_RD   = 4'd7,
    CMD_LOOP_STEP = 4'd8,
    CMD_LOOP_END  = 4'd9,
    CMD_EMIT      = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_GOTO     = 3'd1,
    JMP_WAIT_IN  = 3'd2,
    JMP_WAIT_OUT = 3'd3,
    JMP_DISPATCH = 3'd4,
    JMP_LOOP     = 3'd5
  } cond_e;

  typedef struct packed {
    cmd_e  cmd;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic  accept;
    logic  out_busy;
    logic  loop_more;
    step_t dispatch;
  } seq_flags_t;

  function automatic uword_t ucode(step_t step);
    uword_t w;
    unique case (step)
      UpcFetch:    w = '{cmd: CMD_FETCH,     cond: JMP_WAIT_IN,  target: UpcDecode};
      UpcDecode:   w = '{cmd: CMD_DECODE,    cond: JMP_DISPATCH, target: UpcDone};
      UpcAppend:   w = '{cmd: CMD_APPEND,    cond: JMP_GOTO,     target: UpcDone};
      UpcRdIssue:  w = '{cmd: CMD_RD_ISSUE,  cond: JMP_NEXT,     target: UpcRdTake};
      UpcRdTake:   w = '{cmd: CMD_RD_TAKE,   cond: JMP_GOTO,     target: UpcDone};
      UpcDropLast: w = '{cmd: CMD_DROP_LAST, cond: JMP_GOTO,     target: UpcDone};
      UpcLoopRd:   w = '{cmd: CMD_LOOP_RD,   cond: JMP_NEXT,     target: UpcLoopStep};
      UpcLoopStep: w = '{cmd: CMD_LOOP_STEP, cond: JMP_LOOP,     target: UpcLoopRd};
      UpcLoopEnd:  w = '{cmd: CMD_LOOP_END,  cond: JMP_NEXT,     target: UpcDone};
      UpcDone:     w = '{cmd: CMD_EMIT,      cond: JMP_WAIT_OUT, target: UpcFetch};
      default:     w = '{cmd: CMD_NOP,       cond: JMP_GOTO,     target: UpcFetch};
    endcase
    return w;
  endfunction

endpackage

// ===== design/cad_if.sv =====
interface cad_in_if;
  import cad_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActW-1:0]    action;
  logic [PosW-1:0]    position;
  logic signed [DataW-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface cad_out_if;
  import cad_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CntOutW-1:0]      entry_count;
  logic signed [DataW-1:0] read_value;
  logic [CntOutW-1:0]      removed;
  logic [StatW-1:0]        status;

  modport source (output valid, entry_count, read_value, removed, status, input ready);
  modport sink   (input valid, entry_count, read_value, removed, status, output ready);
endinterface

// ===== design/cad_seq.sv =====
module cad_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cad_pkg::seq_flags_t flags_i,
  output cad_pkg::uword_t     uword_o
);
  import cad_pkg::*;

  step_t  upc_q, upc_d;
  uword_t uw;

  assign uw      = ucode(upc_q);
  assign uword_o = uw;

  always_comb begin
    case (uw.cond)
      JMP_NEXT:     upc_d = upc_q + step_t'(1);
      JMP_GOTO:     upc_d = uw.target;
      JMP_WAIT_IN:  upc_d = flags_i.accept ? uw.target : upc_q;
      JMP_WAIT_OUT: upc_d = flags_i.out_busy ? upc_q : uw.target;
      JMP_DISPATCH: upc_d = flags_i.dispatch;
      JMP_LOOP:     upc_d = flags_i.loop_more ? uw.target : upc_q + step_t'(1);
      default:      upc_d = UpcFetch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcFetch;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== design/compacting_array_delete.sv =====
// Packed array of up to CAPACITY signed 32-bit entries with append, read and
// deletes that close the gap. One operation is in flight at a time; each gives
// exactly one result. Each operation passes the fetch and decode steps after
// the input transfer; append, read and delete last then run their own steps,
// while any operation that fails its check (full, empty, index out of range) or
// has an unused code goes straight to the result step. Delete at index, delete
// first and delete value walk the entries from the start place (the index, or
// 0) to the end, each entry taking an entry memory read step and then a
// conditional write back step. The result sits in an output register, so the
// next operation is taken while it waits; the sequencer holds in its result step
// only while that register is full and not yet taken. No clearing pass after reset.
module compacting_array_delete #(
  parameter int CAPACITY = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  cad_in_if.sink          req_i,
  cad_out_if.source       rsp_o
);
  import cad_pkg::*;

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int CmpW  = (CntW > PosW) ? CntW : PosW;

  uword_t     uw;
  seq_flags_t flags;

  logic [CntW-1:0]   held_q, held_d;
  logic [CntW-1:0]   src_q, dst_q, gone_q;
  logic [ActW-1:0]   act_q;
  logic [PosW-1:0]   pos_q;
  logic [DataW-1:0]  val_q, rdv_q, rdata_q;
  status_e           status_q, status_dec;
  step_t             dispatch;

  logic [DataW-1:0]  mem_q [CAPACITY];
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [DataW-1:0]  mem_wdata;

  logic                out_valid_q;
  logic [CntOutW-1:0]  out_count_q, out_removed_q;
  logic [DataW-1:0]    out_read_q;
  logic [StatW-1:0]    out_status_q;

  logic              accept, out_busy, out_load;
  logic              full, empty, oor, val_mode, drop, keep, loop_more;
  logic [CmpW-1:0]   pos_w, held_w;
  logic [CntW-1:0]   src_inc;

  cad_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  assign req_i.ready = (uw.cmd == CMD_FETCH);
  assign accept      = req_i.valid && req_i.ready;
  assign out_busy    = out_valid_q && !rsp_o.ready;
  assign out_load    = (uw.cmd == CMD_EMIT) && !out_busy;

  assign pos_w    = CmpW'(pos_q);
  assign held_w   = CmpW'(held_q);
  assign full     = held_q >= CntW'(CAPACITY);
  assign empty    = (held_q == '0);
  assign oor      = pos_w >= held_w;
  assign val_mode = (act_q == ACT_DEL_VALUE);
  // index deletes drop the entry at the start place, where src and dst still meet
  assign drop     = val_mode ? (rdata_q == val_q) : (src_q == dst_q);
  assign keep     = !drop;
  assign src_inc  = src_q + CntW'(1);
  assign loop_more = src_inc < held_q;

  always_comb begin
    dispatch   = UpcDone;
    status_dec = ST_OK;
    case (act_q)
      ACT_APPEND: begin
        if (full) status_dec = ST_FULL;
        else dispatch = UpcAppend;
      end
      ACT_DEL_AT: begin
        if (oor) status_dec = ST_RANGE;
        else dispatch = UpcLoopRd;
      end
      ACT_DEL_FIRST, ACT_DEL_VALUE: begin
        if (empty) status_dec = ST_RANGE;
        else dispatch = UpcLoopRd;
      end
      ACT_DEL_LAST: begin
        if (empty) status_dec = ST_RANGE;
        else dispatch = UpcDropLast;
      end
      ACT_READ: begin
        if (oor) status_dec = ST_RANGE;
        else dispatch = UpcRdIssue;
      end
      default: begin
        dispatch   = UpcDone;
        status_dec = ST_OK;
      end
    endcase
  end

  assign flags = '{accept: accept, out_busy: out_busy, loop_more: loop_more,
                   dispatch: dispatch};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_q[AddrW-1:0];
    mem_wdata = rdata_q;
    mem_raddr = src_q[AddrW-1:0];
    held_d    = held_q;
    unique case (uw.cmd)
      CMD_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = held_q[AddrW-1:0];
        mem_wdata = val_q;
        held_d    = held_q + CntW'(1);
      end
      CMD_RD_ISSUE:  mem_raddr = pos_w[AddrW-1:0];
      CMD_DROP_LAST: held_d = held_q - CntW'(1);
      CMD_LOOP_STEP: mem_we = keep;
      CMD_LOOP_END:  held_d = dst_q;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= req_i.action;
      pos_q  <= req_i.position;
      val_q  <= req_i.value;
      gone_q <= '0;
      rdv_q  <= '0;
    end
    unique case (uw.cmd)
      CMD_DECODE: begin
        status_q <= status_dec;
        if (act_q == ACT_DEL_AT) begin
          src_q <= pos_w[CntW-1:0];
          dst_q <= pos_w[CntW-1:0];
        end else begin
          src_q <= '0;
          dst_q <= '0;
        end
      end
      CMD_RD_TAKE:   rdv_q <= rdata_q;
      CMD_DROP_LAST: gone_q <= CntW'(1);
      CMD_LOOP_STEP: begin
        src_q <= src_inc;
        if (keep) dst_q <= dst_q + CntW'(1);
      end
      CMD_LOOP_END: begin
        gone_q <= held_q - dst_q;
        if (val_mode && (held_q == dst_q)) status_q <= ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_count_q   <= CntOutW'(held_q);
      out_read_q    <= rdv_q;
      out_removed_q <= CntOutW'(gone_q);
      out_status_q  <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.read_value  = out_read_q;
  assign rsp_o.removed     = out_removed_q;
  assign rsp_o.status      = out_status_q;

endmodule

// ===== design/cad_checker.sv =====
`include "compacting_array_delete_defines.svh"

module cad_checker #(
  parameter int CAPACITY = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [cad_pkg::CntOutW-1:0]     rsp_entry_count_i,
  input logic [cad_pkg::DataW-1:0]       rsp_read_value_i,
  input logic [cad_pkg::CntOutW-1:0]     rsp_removed_i,
  input logic [cad_pkg::StatW-1:0]       rsp_status_i
);
  import cad_pkg::*;

  // a stalled result stays put
  `CAD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_entry_count_i) && $stable(rsp_read_value_i) && $stable(rsp_removed_i) && $stable(rsp_status_i))

  // one operation at a time
  `CAD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  `CAD_ASSERT_SAME(a_count_bound, clk_i, rst_ni, rsp_valid_i, (CAPACITY > 31) || (int'(rsp_entry_count_i) <= CAPACITY))

  // a failed operation removes nothing and reads nothing
  `CAD_ASSERT_SAME(a_fail_quiet, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != ST_OK), (rsp_removed_i == '0) && (rsp_read_value_i == '0))

endmodule

bind compacting_array_delete cad_checker #(.CAPACITY(CAPACITY)) u_cad_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_entry_count_i (rsp_o.entry_count),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_removed_i     (rsp_o.removed),
  .rsp_status_i      (rsp_o.status)
);
